/* rtl/ps2km_pkg.sv */
`timescale 1ns / 1ps

package ps2km_pkg;

	// Key code: E0 prefix flag above the set-2 scan code byte
	localparam int unsigned CODE_W  = 9;
	localparam int unsigned ROWS    = 8;
	localparam int unsigned COLS    = 8;
	localparam int unsigned MAT_W   = ROWS * COLS;
	localparam int unsigned MOD_W   = 3;

	// Modifier line positions
	localparam int unsigned MOD_SHIFT = 0;
	localparam int unsigned MOD_CTRL  = 1;
	localparam int unsigned MOD_CAPS  = 2;

	// Modifier key codes
	localparam logic [CODE_W-1:0] CODE_LSHIFT = 9'h012;
	localparam logic [CODE_W-1:0] CODE_RSHIFT = 9'h059;
	localparam logic [CODE_W-1:0] CODE_LCTRL  = 9'h014;
	localparam logic [CODE_W-1:0] CODE_RCTRL  = 9'h114;
	localparam logic [CODE_W-1:0] CODE_CAPS   = 9'h058;

	typedef struct packed {
		logic       hit;
		logic [2:0] row;
		logic [2:0] col;
	} key_pos_t;

	// Decoded event handed to the matrix state
	typedef struct packed {
		key_pos_t key;
		logic     shift_hit;
		logic     ctrl_hit;
		logic     caps_hit;
		logic     release_req;
	} key_evt_t;

	// Key code to matrix position; position written as octal row, column
	function automatic key_pos_t key_lookup(input logic [CODE_W-1:0] code);
		logic [5:0] pos;
		logic       hit;
		key_pos_t   p;
		hit = 1'b1;
		pos = 6'o00;
		case (code)
			9'h16C: pos = 6'o00;
			9'h169: pos = 6'o01;
			9'h170: pos = 6'o02;
			9'h005: pos = 6'o03;
			9'h006: pos = 6'o04;
			9'h004: pos = 6'o05;
			9'h00C: pos = 6'o06;
			9'h00D: pos = 6'o10;
			9'h15A: pos = 6'o11;
			9'h05A: pos = 6'o12;
			9'h066: pos = 6'o13;
			9'h16B: pos = 6'o14;
			9'h175: pos = 6'o15;
			9'h174: pos = 6'o16;
			9'h172: pos = 6'o17;
			9'h045: pos = 6'o20;
			9'h016: pos = 6'o21;
			9'h01E: pos = 6'o22;
			9'h026: pos = 6'o23;
			9'h025: pos = 6'o24;
			9'h02E: pos = 6'o25;
			9'h036: pos = 6'o26;
			9'h03D: pos = 6'o27;
			9'h03E: pos = 6'o30;
			9'h046: pos = 6'o31;
			9'h07C: pos = 6'o32;
			9'h04C: pos = 6'o33;
			9'h041: pos = 6'o34;
			9'h04E: pos = 6'o35;
			9'h049: pos = 6'o36;
			9'h04A: pos = 6'o37;
			9'h14A: pos = 6'o40;
			9'h01C: pos = 6'o41;
			9'h032: pos = 6'o42;
			9'h021: pos = 6'o43;
			9'h023: pos = 6'o44;
			9'h024: pos = 6'o45;
			9'h02B: pos = 6'o46;
			9'h034: pos = 6'o47;
			9'h033: pos = 6'o50;
			9'h043: pos = 6'o51;
			9'h03B: pos = 6'o52;
			9'h042: pos = 6'o53;
			9'h04B: pos = 6'o54;
			9'h03A: pos = 6'o55;
			9'h031: pos = 6'o56;
			9'h044: pos = 6'o57;
			9'h04D: pos = 6'o60;
			9'h015: pos = 6'o61;
			9'h02D: pos = 6'o62;
			9'h01B: pos = 6'o63;
			9'h02C: pos = 6'o64;
			9'h03C: pos = 6'o65;
			9'h02A: pos = 6'o66;
			9'h01D: pos = 6'o67;
			9'h022: pos = 6'o70;
			9'h035: pos = 6'o71;
			9'h01A: pos = 6'o72;
			9'h054: pos = 6'o73;
			9'h05D: pos = 6'o74;
			9'h05B: pos = 6'o75;
			9'h00E: pos = 6'o76;
			9'h029: pos = 6'o77;
			default: hit = 1'b0;
		endcase
		p.hit = hit;
		p.row = pos[5:3];
		p.col = pos[2:0];
		return p;
	endfunction

endpackage

/* rtl/ps2km_decode.sv */
`timescale 1ns / 1ps

module ps2km_decode (
	input  logic [ps2km_pkg::CODE_W-1:0] code,
	input  logic                         release_req,
	output ps2km_pkg::key_evt_t          evt
);
	import ps2km_pkg::*;

	always_comb begin
		evt.key         = key_lookup(code);
		evt.shift_hit   = (code == CODE_LSHIFT) || (code == CODE_RSHIFT);
		evt.ctrl_hit    = (code == CODE_LCTRL) || (code == CODE_RCTRL);
		evt.caps_hit    = (code == CODE_CAPS);
		evt.release_req = release_req;
	end

endmodule

/* rtl/ps2km_state.sv */
`timescale 1ns / 1ps

module ps2km_state (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         evt_valid,
	input  ps2km_pkg::key_evt_t          evt,
	output logic                         evt_ready,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ps2km_pkg::MAT_W-1:0]  matrix_q,
	output logic [ps2km_pkg::MOD_W-1:0]  mod_q,
	output logic                         matched_q
);
	import ps2km_pkg::*;

	logic       out_valid_q;
	logic       advance;
	logic [5:0] idx;

	assign evt_ready = !out_valid_q || out_ready;
	assign advance   = evt_valid && evt_ready;
	assign idx       = {evt.key.row, evt.key.col};
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			matrix_q    <= '1;
			mod_q       <= '1;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				// release sets the active-low bit, press clears it
				if (evt.key.hit)
					matrix_q[idx] <= evt.release_req;
				if (evt.shift_hit)
					mod_q[MOD_SHIFT] <= evt.release_req;
				if (evt.ctrl_hit)
					mod_q[MOD_CTRL] <= evt.release_req;
				if (evt.caps_hit)
					mod_q[MOD_CAPS] <= evt.release_req;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			matched_q <= evt.key.hit;
	end

	a_press_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && evt.key.hit && !evt.release_req |=> matrix_q[$past(idx)] == 1'b0)
		else $error("pressed key bit not cleared");

	a_release_sets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && evt.key.hit && evt.release_req |=> matrix_q[$past(idx)] == 1'b1)
		else $error("released key bit not set");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(matrix_q) && $stable(mod_q))
		else $error("state changed without an event");

	a_miss_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !evt.key.hit |=> $stable(matrix_q))
		else $error("unmatched code changed the matrix");

endmodule

/* rtl/ps2_key_to_matrix_top.sv */
`timescale 1ns / 1ps

// Channel   Dir  tdata (low bit up)                            tuser (low bit up)
// s_axis    in   scan_code[7:0]                                extended, release_req
// m_axis    out  matrix_bits[63:0], shift_up, ctrl_up,          key_matched
//                caps_up, zero pad to 72 bits
//
// One key request is taken per cycle while results are taken; a request passes
// through the input register and then the matrix/result register, which offers
// the result.
// The table match and row bit update sit between those two registers.
// Reset releases every key: all matrix bits and modifier lines read one.
// A stalled result holds; the input register takes one more request, then
// tready drops until the result is taken.

module ps2_key_to_matrix_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // scan_code[7:0]
	input  logic [1:0]  s_axis_tuser,   // extended, release_req
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // matrix_bits[63:0], shift_up, ctrl_up, caps_up, pad
	output logic [0:0]  m_axis_tuser    // key_matched
);
	import ps2km_pkg::*;

	// Input register stage
	logic               valid_s1;
	logic [CODE_W-1:0]  code_s1;
	logic               release_s1;

	logic               evt_ready;
	key_evt_t           evt;
	logic [MAT_W-1:0]   matrix_q;
	logic [MOD_W-1:0]   mod_q;
	logic               matched_q;

	// Take a new request when the stage is empty or drains this cycle
	assign s_axis_tready = !valid_s1 || evt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Hold the payload while stalled; the E0 flag forms the top code bit
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			code_s1    <= {s_axis_tuser[0], s_axis_tdata};
			release_s1 <= s_axis_tuser[1];
		end
	end

	ps2km_decode u_decode (
		.code        (code_s1),
		.release_req (release_s1),
		.evt         (evt)
	);

	// Matrix and modifier registers double as the result register
	ps2km_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (valid_s1),
		.evt       (evt),
		.evt_ready (evt_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.matrix_q  (matrix_q),
		.mod_q     (mod_q),
		.matched_q (matched_q)
	);

	assign m_axis_tdata = {5'b0, mod_q[MOD_CAPS], mod_q[MOD_CTRL], mod_q[MOD_SHIFT], matrix_q};
	assign m_axis_tuser = matched_q;

endmodule
